@@ design/wsg_pkg.sv @@
// ----------------------------------------------------------------------------
// Waveform sample generator package
// Shared constants, codes and types of the waveform sample generator.
// ----------------------------------------------------------------------------
package wsg_pkg;

    localparam int unsigned CARRIER_RATIO_DEF    = 21;
    localparam int unsigned SINE_TABLE_DEPTH_DEF = 256;
    localparam int unsigned PHASE_BITS_DEF       = 16;

    localparam logic [7:0]  CENTER_LEVEL = 8'd114;
    localparam logic [6:0]  SPREAD_MAX   = 7'd102;
    localparam logic [16:0] UNIT_Q16     = 17'd65536;
    localparam logic [15:0] HALF_Q16     = 16'd32768;
    localparam longint unsigned PI_Q30   = 64'd3373259426;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 3;

    // Word index of each configuration register.
    localparam logic REG_SPWM_MODE = 1'b0;

    typedef enum logic [2:0] {
        KIND_SINE     = 3'd0,
        KIND_SAW      = 3'd1,
        KIND_SQUARE   = 3'd2,
        KIND_TRIANGLE = 3'd3,
        KIND_INV_SAW  = 3'd4
    } t_wave_kind;

endpackage

@@ design/waveform_sample_generator_top.sv @@
// ----------------------------------------------------------------------------
// Waveform sample generator
// Turns a wave kind, a phase and an amplitude spread into one drive byte,
// either as a direct level or as sinusoidal PWM against a phase carrier.
//
// The input channel takes one word per cycle on i_in_valid while o_in_stall
// is low; each word carries a wave kind, a phase fraction and a spread. The
// output channel presents one sample byte per input word on o_out_valid and
// holds it while i_out_stall is high. A word passes an input register and a
// result register before its sample is presented, and one word is accepted
// every cycle when the receiver does not stall. The path between the two
// registers holds the quarter-wave sine table read, the spread multiplier
// and the carrier compare. When the receiver stalls, the result register
// holds and the input register fills; o_in_stall rises only once both are
// occupied. Reset empties both registers and clears spwm_mode. The APB port
// holds spwm_mode at byte address 0; pready is always high.
// ----------------------------------------------------------------------------
module waveform_sample_generator_top #(
    parameter int unsigned CARRIER_RATIO    = wsg_pkg::CARRIER_RATIO_DEF,
    parameter int unsigned SINE_TABLE_DEPTH = wsg_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int unsigned PHASE_BITS       = wsg_pkg::PHASE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [2:0]                          i_wave_kind,
    input  logic [15:0]                         i_phase_fraction,
    input  logic [6:0]                          i_amplitude_spread,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [7:0]                          o_sample_byte,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wsg_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [wsg_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [wsg_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int unsigned KW = $clog2(4 * SINE_TABLE_DEPTH);
    localparam int unsigned IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int unsigned MW = PHASE_BITS + KW;

    // Quarter-wave sine point in Q1.16, from an eight-term series.
    function automatic logic [16:0] sine_point(input int unsigned idx);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned t;
        longint          sum;
        begin
            x    = (64'(idx) * wsg_pkg::PI_Q30) / (2 * SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                t = (term * x2) >> 30;
                case (k)
                    1: term = t / 6;
                    2: term = t / 20;
                    3: term = t / 42;
                    4: term = t / 72;
                    5: term = t / 110;
                    6: term = t / 156;
                    default: term = t / 210;
                endcase
                if (k % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            sum = (sum + 8192) >>> 14;
            if (sum > 65536) begin
                sum = 65536;
            end
            return 17'(sum);
        end
    endfunction

    logic [16:0] w_sine_lut [0:SINE_TABLE_DEPTH];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_lut
        assign w_sine_lut[g] = sine_point(g);
    end

    // Configuration register.
    logic r_spwm_mode;
    logic w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spwm_mode <= 1'b0;
        end else if (w_cfg_wr && paddr[2] == wsg_pkg::REG_SPWM_MODE) begin
            r_spwm_mode <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == wsg_pkg::REG_SPWM_MODE) begin
            prdata[0] = r_spwm_mode;
        end
    end

    // Pipeline control.
    logic r_s1_valid;
    logic r_s2_valid;
    logic w_en2;
    logic w_en1;

    assign w_en2      = !r_s2_valid || !i_out_stall;
    assign w_en1      = !r_s1_valid || w_en2;
    assign o_in_stall = !w_en1;
    assign o_out_valid = r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_en1) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_en2) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // Input register.
    logic [2:0]  r_s1_kind;
    logic [15:0] r_s1_phase;
    logic [6:0]  r_s1_spread;

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_in_valid) begin
            r_s1_kind   <= i_wave_kind;
            r_s1_phase  <= i_phase_fraction;
            r_s1_spread <= i_amplitude_spread;
        end
    end

    // Phase in its native width and in Q0.16.
    logic [PHASE_BITS-1:0] w_p;
    logic [15:0]           w_p16;

    if (PHASE_BITS >= 16) begin : g_wide_phase
        assign w_p   = PHASE_BITS'(r_s1_phase);
        assign w_p16 = 16'(w_p >> (PHASE_BITS - 16));
    end else begin : g_narrow_phase
        assign w_p   = r_s1_phase[PHASE_BITS-1:0];
        assign w_p16 = 16'({w_p, {(16 - PHASE_BITS){1'b0}}});
    end

    // Sine quadrant and table index.
    logic [MW-1:0]  w_kprod;
    logic [KW-1:0]  w_k;
    logic [1:0]     w_quad;
    logic [KW-1:0]  w_rem;
    logic [IW-1:0]  w_idx;
    logic [16:0]    w_mag;
    logic [16:0]    w_sine_val;

    assign w_kprod = MW'(w_p) * MW'(4 * SINE_TABLE_DEPTH);
    assign w_k     = KW'(w_kprod >> PHASE_BITS);

    always_comb begin
        if (w_k >= KW'(3 * SINE_TABLE_DEPTH)) begin
            w_quad = 2'd3;
            w_rem  = w_k - KW'(3 * SINE_TABLE_DEPTH);
        end else if (w_k >= KW'(2 * SINE_TABLE_DEPTH)) begin
            w_quad = 2'd2;
            w_rem  = w_k - KW'(2 * SINE_TABLE_DEPTH);
        end else if (w_k >= KW'(SINE_TABLE_DEPTH)) begin
            w_quad = 2'd1;
            w_rem  = w_k - KW'(SINE_TABLE_DEPTH);
        end else begin
            w_quad = 2'd0;
            w_rem  = w_k;
        end
        if (w_quad[0]) begin
            w_idx = IW'(SINE_TABLE_DEPTH) - IW'(w_rem);
        end else begin
            w_idx = IW'(w_rem);
        end
        w_mag = w_sine_lut[w_idx];
        if (!w_quad[1]) begin
            w_sine_val = 17'((18'(wsg_pkg::UNIT_Q16) + 18'(w_mag)) >> 1);
        end else begin
            w_sine_val = (wsg_pkg::UNIT_Q16 - w_mag) >> 1;
        end
    end

    // Unit level of the selected wave.
    logic [16:0] w_val;

    always_comb begin
        case (wsg_pkg::t_wave_kind'(r_s1_kind))
            wsg_pkg::KIND_SINE: begin
                w_val = w_sine_val;
            end
            wsg_pkg::KIND_SAW: begin
                w_val = 17'(w_p16);
            end
            wsg_pkg::KIND_SQUARE: begin
                w_val = (w_p16 < wsg_pkg::HALF_Q16) ? wsg_pkg::UNIT_Q16 : 17'd0;
            end
            wsg_pkg::KIND_TRIANGLE: begin
                if (w_p16 < wsg_pkg::HALF_Q16) begin
                    w_val = {w_p16, 1'b0};
                end else begin
                    w_val = wsg_pkg::UNIT_Q16
                          - {(w_p16 - wsg_pkg::HALF_Q16), 1'b0};
                end
            end
            wsg_pkg::KIND_INV_SAW: begin
                w_val = wsg_pkg::UNIT_Q16 - 17'(w_p16);
            end
            default: begin
                w_val = 17'd0;
            end
        endcase
    end

    // Output level.
    logic [6:0]  w_spread;
    logic [24:0] w_scaled;
    logic [15:0] w_carrier;
    logic [7:0]  n_sample;

    assign w_spread  = (r_s1_spread > wsg_pkg::SPREAD_MAX) ? wsg_pkg::SPREAD_MAX
                                                           : r_s1_spread;
    assign w_scaled  = 25'(w_val) * 25'({w_spread, 1'b0});
    assign w_carrier = 16'(24'(w_p16) * 24'(CARRIER_RATIO));

    always_comb begin
        if (!r_spwm_mode) begin
            n_sample = wsg_pkg::CENTER_LEVEL - 8'(w_spread) + 8'(w_scaled >> 16);
        end else if (w_val >= 17'(w_carrier)) begin
            n_sample = wsg_pkg::CENTER_LEVEL + 8'(w_spread);
        end else begin
            n_sample = wsg_pkg::CENTER_LEVEL - 8'(w_spread);
        end
    end

    // Result register.
    logic [7:0] r_s2_sample;

    always_ff @(posedge i_clk) begin
        if (w_en2 && r_s1_valid) begin
            r_s2_sample <= n_sample;
        end
    end

    assign o_sample_byte = r_s2_sample;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Waveform sample generator testbench
// Drives wave kind, phase and spread words into the generator in random
// bursts while the receiver stalls on a changing pattern. A scoreboard
// predicts every sample byte from its own quarter-wave sine table and checks
// the bytes in order. The PWM mode register is switched between phases.
// ----------------------------------------------------------------------------
typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] phase;
    logic [6:0]  spread;
} t_word;

typedef struct packed {
    t_word      word;
    logic [7:0] level;
} t_sample;

class sample_checker;
    bit             spwm_on;
    int             failures;
    t_sample        pending_samples[$];
    int unsigned    sine_quarter[wsg_pkg::SINE_TABLE_DEPTH_DEF + 1];

    function new();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        spwm_on  = 1'b0;
        failures = 0;
        for (int i = 0; i <= wsg_pkg::SINE_TABLE_DEPTH_DEF; i++) begin
            x    = (longint'(i) * wsg_pkg::PI_Q30)
                 / (2 * wsg_pkg::SINE_TABLE_DEPTH_DEF);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            sum = (sum + 8192) >>> 14;
            if (sum > longint'(wsg_pkg::UNIT_Q16)) begin
                sum = longint'(wsg_pkg::UNIT_Q16);
            end
            sine_quarter[i] = int'(sum);
        end
    endfunction

    function int unsigned sine_level(logic [15:0] phase);
        int unsigned depth;
        int unsigned step;
        int unsigned quadrant;
        int unsigned offset;
        int unsigned mag;
        depth    = wsg_pkg::SINE_TABLE_DEPTH_DEF;
        step     = (int'(phase) * 4 * depth) >> wsg_pkg::PHASE_BITS_DEF;
        quadrant = (step / depth) % 4;
        offset   = step % depth;
        mag      = (quadrant % 2 == 1) ? sine_quarter[depth - offset]
                                       : sine_quarter[offset];
        if (quadrant < 2) begin
            return (int'(wsg_pkg::UNIT_Q16) + mag) >> 1;
        end
        return (int'(wsg_pkg::UNIT_Q16) - mag) >> 1;
    endfunction

    function logic [7:0] level_for(t_word w);
        int unsigned spread;
        int unsigned p16;
        int unsigned val;
        int unsigned carrier;
        int unsigned level;
        int unsigned unit;
        int unsigned half;
        int unsigned center;
        unit   = int'(wsg_pkg::UNIT_Q16);
        half   = int'(wsg_pkg::HALF_Q16);
        center = int'(wsg_pkg::CENTER_LEVEL);
        spread = (w.spread > wsg_pkg::SPREAD_MAX) ? int'(wsg_pkg::SPREAD_MAX)
                                                  : int'(w.spread);
        p16    = int'(w.phase);
        case (w.kind)
            wsg_pkg::KIND_SINE:     val = sine_level(w.phase);
            wsg_pkg::KIND_SAW:      val = p16;
            wsg_pkg::KIND_SQUARE:   val = (p16 < half) ? unit : 0;
            wsg_pkg::KIND_TRIANGLE: val = (p16 < half) ? 2 * p16
                                          : unit - 2 * (p16 - half);
            wsg_pkg::KIND_INV_SAW:  val = unit - p16;
            default:                val = 0;
        endcase
        if (!spwm_on) begin
            level = center - spread + ((val * (2 * spread)) >> 16);
        end else begin
            carrier = (p16 * wsg_pkg::CARRIER_RATIO_DEF) % 65536;
            level   = (val >= carrier) ? center + spread : center - spread;
        end
        return level[7:0];
    endfunction

    function void report(string msg);
        failures++;
        if (failures <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function void note_word(t_word w);
        t_sample s;
        s.word  = w;
        s.level = level_for(w);
        pending_samples.push_back(s);
    endfunction

    function void check_sample(logic [7:0] actual);
        t_sample s;
        if (pending_samples.size() == 0) begin
            report($sformatf("Unexpected sample byte %0d.", actual));
            return;
        end
        s = pending_samples.pop_front();
        if (actual !== s.level) begin
            report($sformatf({"Sample mismatch: kind %0d phase %h spread %0d pwm %0d,",
                              " expected %0d, got %0d."},
                             s.word.kind, s.word.phase, s.word.spread, spwm_on,
                             s.level, actual));
        end
    endfunction

    function void close();
        while (pending_samples.size() != 0) begin
            void'(pending_samples.pop_front());
            report("A sample byte never arrived.");
        end
    endfunction
endclass

module testbench;

    localparam logic [2:0] KIND_MAX = 3'd7;

    logic                           i_clk              = 1'b0;
    logic                           i_rst_n            = 1'b0;
    logic                           i_in_valid         = 1'b0;
    logic                           o_in_stall;
    logic [2:0]                     i_wave_kind        = '0;
    logic [15:0]                    i_phase_fraction   = '0;
    logic [6:0]                     i_amplitude_spread = '0;
    logic                           o_out_valid;
    logic                           i_out_stall        = 1'b0;
    logic [7:0]                     o_sample_byte;
    logic                           psel               = 1'b0;
    logic                           penable            = 1'b0;
    logic                           pwrite             = 1'b0;
    logic [wsg_pkg::CFG_ADDR_W-1:0] paddr              = '0;
    logic [wsg_pkg::CFG_DATA_W-1:0] pwdata             = '0;
    logic [wsg_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    sample_checker sb;
    int            burst_left  = 0;
    logic [15:0]   stall_cycle = '0;
    int            stall_style = 0;

    waveform_sample_generator_top u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_wave_kind        (i_wave_kind),
        .i_phase_fraction   (i_phase_fraction),
        .i_amplitude_spread (i_amplitude_spread),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_sample_byte      (o_sample_byte),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        stall_cycle <= stall_cycle + 16'd1;
        if (stall_cycle[5:0] == 6'd0) begin
            stall_style <= $urandom_range(0, 3);
        end
        case (stall_style)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= stall_cycle[1];
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_sample(o_sample_byte);
        end
    end

    task automatic push_word(input t_word w);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid         <= 1'b1;
        i_wave_kind        <= w.kind;
        i_phase_fraction   <= w.phase;
        i_amplitude_spread <= w.spread;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(w);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_samples.size() != 0) @(posedge i_clk);
    endtask

    task automatic program_mode(input bit mode);
        logic [wsg_pkg::CFG_ADDR_W-1:0] addr;
        addr    = wsg_pkg::CFG_ADDR_W'(4 * int'(wsg_pkg::REG_SPWM_MODE));
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= wsg_pkg::CFG_DATA_W'(mode);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.spwm_on = mode;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== wsg_pkg::CFG_DATA_W'(mode)) begin
            sb.report($sformatf("Mode read back %0d, expected %0d.", prdata, mode));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_directed();
        t_word list [13] = '{
            '{wsg_pkg::KIND_SINE,            16'h0000, 7'd127},
            '{wsg_pkg::KIND_SINE,            16'h4000, 7'd102},
            '{wsg_pkg::KIND_SINE,            16'hC000, 7'd103},
            '{wsg_pkg::KIND_SINE,            16'hFFFF, 7'd50},
            '{wsg_pkg::KIND_SAW,             16'hFFFF, 7'd127},
            '{wsg_pkg::KIND_SQUARE,          16'h7FFF, 7'd102},
            '{wsg_pkg::KIND_SQUARE,          16'h8000, 7'd102},
            '{wsg_pkg::KIND_TRIANGLE,        16'h8000, 7'd127},
            '{wsg_pkg::KIND_TRIANGLE,        16'h7FFF, 7'd1},
            '{wsg_pkg::KIND_INV_SAW,         16'h0000, 7'd127},
            '{wsg_pkg::KIND_INV_SAW + 3'd1,  16'h1234, 7'd0},
            '{wsg_pkg::KIND_INV_SAW + 3'd2,  16'h0C30, 7'd64},
            '{KIND_MAX,                      16'hFFFF, 7'd127}
        };
        foreach (list[i]) begin
            push_word(list[i]);
        end
    endtask

    function automatic t_word random_word();
        t_word       w;
        logic [15:0] corners [8] = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000,
                                     16'h3FFF, 16'h4000, 16'hBFFF, 16'hC000};
        logic [6:0]  spreads [6] = '{7'd0, 7'd1, 7'd101, 7'd102, 7'd103, 7'd127};
        if ($urandom_range(0, 9) < 8) begin
            w.kind = 3'($urandom_range(int'(wsg_pkg::KIND_SINE),
                                       int'(wsg_pkg::KIND_INV_SAW)));
        end else begin
            w.kind = 3'($urandom_range(int'(wsg_pkg::KIND_INV_SAW) + 1,
                                       int'(KIND_MAX)));
        end
        w.phase  = ($urandom_range(0, 7) == 0) ? corners[$urandom_range(0, 7)]
                                               : 16'($urandom);
        w.spread = ($urandom_range(0, 3) == 0) ? spreads[$urandom_range(0, 5)]
                                               : 7'($urandom_range(0, 127));
        return w;
    endfunction

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        program_mode(1'b0);
        run_directed();
        drain();
        program_mode(1'b1);
        run_directed();
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            program_mode(ph % 2 == 1);
            repeat (356) push_word(random_word());
            drain();
        end
        repeat (10) @(posedge i_clk);
        sb.close();
        if (sb.failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
